// ===== rtl/sbw_pkg.sv =====
// sbw_pkg: shared types and constants for the stuffed bit writer
// input and output word structs, opcodes, controller states, command/status groups
// no dependencies
package sbw_pkg;

  localparam int unsigned MaxBits = 32;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_RAW   = 2'd2;

  localparam logic [7:0] BYTE_FF  = 8'hFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] bit_value;
    logic [5:0]  bit_count;
    logic [7:0]  raw_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic done;
    logic emit;
  } sts_t;

endpackage

// ===== rtl/sbw_ctrl.sv =====
// sbw_ctrl: controller state machine of the stuffed bit writer
// takes words in, sequences datapath steps; depends on sbw_pkg
module sbw_ctrl import sbw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WORK;
        end
      end
      ST_WORK: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.done) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sbw_datapath.sv =====
// sbw_datapath: bit packing datapath with stuffing and output register
// one step moves up to a byte's worth of bits; depends on sbw_pkg
module sbw_datapath import sbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [1:0]  op_q;
  logic [31:0] val_q;
  logic [5:0]  rem_q;
  logic [7:0]  raw_q;
  logic [7:0]  pend_q, pend_d;
  logic [2:0]  fill_q, fill_d;
  logic [5:0]  rem_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;

  logic [3:0]  avail;
  logic [3:0]  take;
  logic [3:0]  new_fill;
  logic [31:0] chunk;
  logic [7:0]  mask;
  logic [7:0]  placed;
  logic [5:0]  rem_next;
  logic [5:0]  sat_count;
  logic        emit;
  logic        done;
  logic [7:0]  emit_byte;
  logic        emit_last;

  assign sat_count = (in_word_i.bit_count > 6'(MaxBits)) ? 6'(MaxBits) : in_word_i.bit_count;

  always_comb begin
    avail    = 4'd8 - {1'b0, fill_q};
    take     = (rem_q < {2'b00, avail}) ? rem_q[3:0] : avail;
    rem_next = rem_q - {2'b00, take};
    chunk    = val_q >> rem_next;
    mask     = 8'((9'd1 << take) - 9'd1);
    placed   = pend_q | 8'((chunk[7:0] & mask) << (avail - take));
    new_fill = {1'b0, fill_q} + take;

    pend_d    = pend_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    done      = 1'b1;
    emit_byte = raw_q;
    emit_last = 1'b1;
    case (op_q)
      OP_WRITE: begin
        rem_d = rem_next;
        done  = (rem_next == 6'd0);
        if (new_fill == 4'd8) begin
          emit      = 1'b1;
          emit_byte = placed;
          // last unless the remaining bits complete another byte
          emit_last = (placed == BYTE_FF) ? (rem_next < 6'd7) : (rem_next < 6'd8);
          pend_d    = 8'h00;
          fill_d    = (placed == BYTE_FF) ? 3'd1 : 3'd0;
        end else begin
          pend_d = placed;
          fill_d = new_fill[2:0];
        end
      end
      OP_FLUSH: begin
        if (fill_q != 3'd0) begin
          emit      = 1'b1;
          emit_byte = pend_q;
          pend_d    = 8'h00;
          fill_d    = 3'd0;
        end
      end
      OP_RAW: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.done     = done;
  assign sts_o.emit     = emit;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.step && emit) begin
      out_valid_d        = 1'b1;
      out_d.out_byte     = emit_byte;
      out_d.last_of_item = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 8'h00;
      fill_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.step) begin
        pend_q <= pend_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load) begin
      op_q  <= in_word_i.opcode;
      val_q <= in_word_i.bit_value;
      rem_q <= (in_word_i.opcode == OP_WRITE) ? sat_count : 6'd0;
      raw_q <= in_word_i.raw_byte;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/stuffed_bit_writer.sv =====
// stuffed_bit_writer: top level of the bit packer with 0xFF bit stuffing
// joins sbw_ctrl and sbw_datapath; depends on sbw_pkg
//
//   channel   direction   handshake              word
//   in        input       in_valid_i/in_stall_o  in_word_t
//   out       output      out_valid_o/out_stall_i out_word_t
//
// an item takes a load and then one step per emitted byte, plus
// one for a trailing partial chunk or an empty write: a write needs 1 to 6
// steps; flush, raw byte and unused opcodes take one step
// reset clears the pending byte, the fill count and the output valid flag
// a stalled output holds the step sequencer; input is stalled while busy
module stuffed_bit_writer import sbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  sbw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_step_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> sts.out_free)
    else $error("step issued while output register blocked");

  a_accept_locks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before item finished");

  a_emit_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && sts.emit) |=> out_valid_o)
    else $error("emitted byte not presented");

  a_no_load_and_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.step))
    else $error("load and step in same cycle");

endmodule

// ===== dv/tb.sv =====
// tb: self-checking testbench for stuffed_bit_writer, random idling on both channels
// directed packing, 0xff stuffing, flush, raw, unused-op tests, then random words
// depends on sbw_pkg and the rtl of stuffed_bit_writer
module tb;
  import sbw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandomWords = 140;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  out_word_t   expected_bytes[$];
  logic [7:0]  pend_byte;
  int unsigned pend_fill;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  stuffed_bit_writer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic in_word_t mk_word(logic [1:0] op, logic [31:0] val, logic [5:0] cnt,
                                       logic [7:0] raw);
    in_word_t w;
    w.opcode    = op;
    w.bit_value = val;
    w.bit_count = cnt;
    w.raw_byte  = raw;
    return w;
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    out_word_t o;
    o.out_byte     = b;
    o.last_of_item = 1'b0;
    expected_bytes.push_back(o);
  endfunction

  // models one accepted word: packs bits, flushes the pending byte or takes a raw byte, queues its bytes
  function automatic void pack_bits(in_word_t w);
    int unsigned n;
    int unsigned produced;
    out_word_t   tail;
    logic [7:0]  done;
    produced = 0;
    case (w.opcode)
      OP_WRITE: begin
        n = (w.bit_count > MaxBits) ? MaxBits : w.bit_count;
        for (int i = n; i > 0; i--) begin
          if (w.bit_value[i-1]) begin
            pend_byte[7 - pend_fill] = 1'b1;
          end
          pend_fill++;
          if (pend_fill == 8) begin
            done = pend_byte;
            queue_byte(done);
            produced++;
            pend_byte = 8'h00;
            pend_fill = (done == BYTE_FF) ? 1 : 0;
          end
        end
      end
      OP_FLUSH: begin
        if (pend_fill != 0) begin
          queue_byte(pend_byte);
          produced++;
          pend_byte = 8'h00;
          pend_fill = 0;
        end
      end
      OP_RAW: begin
        queue_byte(w.raw_byte);
        produced++;
      end
      default: begin
      end
    endcase
    if (produced > 0) begin
      tail = expected_bytes.pop_back();
      tail.last_of_item = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pack_bits(w);
  endtask

  task automatic sender_pause();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic put(logic [1:0] op, logic [31:0] val, logic [5:0] cnt, logic [7:0] raw);
    send_word(mk_word(op, val, cnt, raw));
    sender_pause();
  endtask

  task automatic test_write_extremes();
    put(OP_WRITE, 32'hFFFF_FFFF, 6'd0, 8'h00);
    put(OP_WRITE, 32'hA5A5_A5A5, 6'd32, 8'hFF);
    put(OP_WRITE, 32'h0000_0001, 6'd1, 8'h00);
    put(OP_WRITE, 32'h1234_5678, 6'd63, 8'h00);
    put(OP_WRITE, 32'hDEAD_BEEF, 6'd33, 8'h00);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  task automatic test_flush();
    put(OP_FLUSH, 32'hFFFF_FFFF, 6'd63, 8'hFF);
    put(OP_WRITE, 32'h0000_0005, 6'd3, 8'h00);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  task automatic test_raw();
    put(OP_RAW, 32'h0, 6'd0, 8'h00);
    put(OP_RAW, 32'hFFFF_FFFF, 6'd32, 8'hFF);
    put(OP_WRITE, 32'h0000_0015, 6'd5, 8'h00);
    put(OP_RAW, 32'h0, 6'd0, 8'h3C);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  task automatic test_stuffing();
    put(OP_WRITE, 32'h0000_00FF, 6'd8, 8'h00);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
    put(OP_WRITE, 32'h0000_00FF, 6'd8, 8'h00);
    put(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 8'h00);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  task automatic test_unused_opcode();
    put(2'd3, 32'hFFFF_FFFF, 6'd63, 8'hFF);
    put(OP_WRITE, 32'h0000_000B, 6'd4, 8'h00);
    put(2'd3, 32'hFFFF_FFFF, 6'd32, 8'hFF);
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned r;
    logic [31:0] val;
    logic [5:0]  cnt;
    logic [7:0]  raw;
    sent = 0;
    while (sent < RandomWords) begin
      r   = $urandom_range(0, 99);
      val = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      cnt = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
                                          6'($urandom_range(0, 32));
      raw = 8'($urandom_range(0, 255));
      if (r < 60) begin
        put(OP_WRITE, val, cnt, raw);
        sent++;
      end else if (r < 75) begin
        put(OP_FLUSH, val, cnt, raw);
        sent++;
      end else if (r < 90) begin
        put(OP_RAW, val, cnt, raw);
        sent++;
      end else begin
        put(2'd3, val, cnt, raw);
      end
    end
    put(OP_FLUSH, 32'h0, 6'd0, 8'h00);
  endtask

  // output stall generator
  initial begin
    int unsigned r;
    int unsigned len;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word exp none got %h/%b", $time,
                 out_word_o.out_byte, out_word_o.last_of_item);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_word_o.out_byte !== want.out_byte) begin
          $display("%0t: out_byte mismatch exp %h got %h", $time,
                   want.out_byte, out_word_o.out_byte);
          errors++;
        end
        if (out_word_o.last_of_item !== want.last_of_item) begin
          $display("%0t: last_of_item mismatch exp %b got %b", $time,
                   want.last_of_item, out_word_o.last_of_item);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    pend_byte  = 8'h00;
    pend_fill  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_write_extremes();
    test_flush();
    test_raw();
    test_stuffing();
    test_unused_opcode();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sbw_pkg.sv
rtl/sbw_ctrl.sv
rtl/sbw_datapath.sv
rtl/stuffed_bit_writer.sv
dv/tb.sv
